// ===== rtl/core/tssg_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the servo gait block.
`default_nettype none

package tssg_pkg;

   localparam int NUM_CH     = 3;
   localparam int CH_W       = 2;
   localparam int PC_W       = 3;
   localparam int SINE_DEPTH = 256;
   localparam int SINE_IDX_W = $clog2(SINE_DEPTH + 1);
   localparam int SINE_SHIFT = 30 - $clog2(SINE_DEPTH);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;

   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
   localparam logic [15:0] ANGLE_MAX_Q8 = 16'd46080;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_STEP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_BASE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_MID    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_TAIL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_BASE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_MID   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_TAIL  = 3'd7;

   typedef enum logic [2:0] {
      OP_BASE,
      OP_PHASE,
      OP_SINE,
      OP_PROD,
      OP_ANGLE,
      OP_COMMIT,
      OP_DONE
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [CH_W-1:0] ch;
      logic            fire;
   } ctrl_type;

   typedef struct packed {
      logic [25:0]             freq_step;
      logic [15:0]             phase_step;
      logic [NUM_CH-1:0][6:0]  amp;
      logic [NUM_CH-1:0][7:0]  trim;
   } cfg_type;

   typedef logic [14:0] sine_rom_type [0:SINE_DEPTH];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type       rom;
      logic [63:0]        th;
      logic [63:0]        th2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      for (int i = 0; i <= SINE_DEPTH; i++) begin
         th   = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
         th2  = (th * th) >> 30;
         term = th;
         sum  = signed'(th);
         term = ((term * th2) >> 30) / 64'd6;
         sum  = sum - signed'(term);
         term = ((term * th2) >> 30) / 64'd20;
         sum  = sum + signed'(term);
         term = ((term * th2) >> 30) / 64'd42;
         sum  = sum - signed'(term);
         term = ((term * th2) >> 30) / 64'd72;
         sum  = sum + signed'(term);
         term = ((term * th2) >> 30) / 64'd110;
         sum  = sum - signed'(term);
         term = ((term * th2) >> 30) / 64'd156;
         sum  = sum + signed'(term);
         term = ((term * th2) >> 30) / 64'd210;
         sum  = sum - signed'(term);
         term = ((term * th2) >> 30) / 64'd272;
         sum  = sum + signed'(term);
         term = ((term * th2) >> 30) / 64'd342;
         sum  = sum - signed'(term);
         if (sum < 0) begin
            sum = 64'sd0;
         end
         r = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
         if (r > 64'sd32767) begin
            r = 64'sd32767;
         end
         rom[i] = r[14:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/core/tssg_seq.sv =====
// Microcode sequencer: program table, step counter, channel counter and jumps.
`default_nettype none

module tssg_seq
   import tssg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     out_blocked,
   output logic          busy,
   output ctrl_type      ctrl
);

   typedef struct packed {
      op_type          op;
      logic            jump;
      logic [PC_W-1:0] target;
   } ucode_type;

   function automatic ucode_type fetch(logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         3'd0:    w = '{op: OP_BASE,   jump: 1'b0, target: 3'd0};
         3'd1:    w = '{op: OP_PHASE,  jump: 1'b0, target: 3'd0};
         3'd2:    w = '{op: OP_SINE,   jump: 1'b0, target: 3'd0};
         3'd3:    w = '{op: OP_PROD,   jump: 1'b0, target: 3'd0};
         3'd4:    w = '{op: OP_ANGLE,  jump: 1'b0, target: 3'd0};
         3'd5:    w = '{op: OP_COMMIT, jump: 1'b1, target: 3'd1};
         default: w = '{op: OP_DONE,   jump: 1'b0, target: 3'd0};
      endcase
      return w;
   endfunction

   ucode_type       word;
   logic            last_ch;
   logic            hold;
   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [CH_W-1:0] ch_ff, ch_in;

   assign word    = fetch(pc_ff);
   assign last_ch = (ch_ff == CH_W'(NUM_CH - 1));
   assign hold    = out_blocked && (word.op == OP_DONE);

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      ch_in   = ch_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
         ch_in   = '0;
      end else if (busy_ff && !hold) begin
         if (word.op == OP_DONE) begin
            busy_in = 1'b0;
         end else if (word.jump && !last_ch) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
         if (word.op == OP_COMMIT && !last_ch) begin
            ch_in = ch_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         ch_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         ch_ff   <= ch_in;
      end
   end

   assign busy      = busy_ff;
   assign ctrl.op   = word.op;
   assign ctrl.ch   = ch_ff;
   assign ctrl.fire = busy_ff && !hold;

endmodule

`default_nettype wire

// ===== rtl/core/tssg_datapath.sv =====
// Shared phase, sine, multiply and angle datapath with channel state and result register.
`default_nettype none

module tssg_datapath
   import tssg_pkg::*;
#(
   parameter int UPDATE_INTERVAL_MS = 20
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire ctrl_type    ctrl,
   input  wire logic        start,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        req_run,
   input  wire logic        rsp_stall,
   output logic             out_blocked,
   output logic             rsp_valid,
   output logic             rsp_write_base,
   output logic [7:0]       rsp_angle_base,
   output logic             rsp_write_mid,
   output logic [7:0]       rsp_angle_mid,
   output logic             rsp_write_tail,
   output logic [7:0]       rsp_angle_tail,
   output logic [2:0]       rsp_parked_flags
);

   logic [31:0]            now_ff;
   logic                   run_ff;
   logic [31:0]            base_ff, base_in;
   logic [SINE_IDX_W-1:0]  idx_ff, idx_in;
   logic                   neg_ff;
   logic signed [15:0]     sine_ff, sine_in;
   logic signed [23:0]     prod_ff, prod_in;
   logic [15:0]            ang_ff, ang_in;
   logic [31:0]            last_ms_ff [NUM_CH];
   logic [NUM_CH-1:0]      parked_ff;
   logic [NUM_CH-1:0]      wr_ff;
   logic [7:0]             deg_ff [NUM_CH];
   logic                   rsp_valid_ff;
   logic [NUM_CH-1:0]      rsp_wr_ff;
   logic [7:0]             rsp_deg_ff [NUM_CH];
   logic [NUM_CH-1:0]      rsp_parked_ff;

   logic [31:0]            gap;
   logic [31:0]            steps_gap;
   logic [31:0]            phase;
   logic [SINE_IDX_W-1:0]  pos_idx;
   logic [15:0]            sine_mag;
   logic [6:0]             amp_sel;
   logic signed [7:0]      trim_sel;
   logic signed [8:0]      centre_deg;
   logic signed [17:0]     centre;
   logic signed [23:0]     rnd;
   logic signed [18:0]     sum;
   logic signed [18:0]     diff;
   logic signed [18:0]     tol;
   logic                   near;
   logic [31:0]            elapsed;
   logic                   due;
   logic [7:0]             park_deg;

   assign gap = {cfg.phase_step, 16'd0};

   always_comb begin
      unique case (ctrl.ch)
         2'd0:    steps_gap = gap << 1;
         2'd1:    steps_gap = gap;
         default: steps_gap = 32'd0;
      endcase
   end

   assign base_in  = 32'(now_ff * 58'(cfg.freq_step));
   assign phase    = base_ff + steps_gap;
   assign pos_idx  = SINE_IDX_W'(phase[29:SINE_SHIFT]);
   assign idx_in   = phase[30] ? SINE_IDX_W'(SINE_DEPTH) - pos_idx : pos_idx;
   assign sine_mag = {1'b0, SINE_ROM[idx_ff]};
   assign sine_in  = neg_ff ? -signed'(sine_mag) : signed'(sine_mag);

   assign amp_sel  = cfg.amp[ctrl.ch];
   assign trim_sel = signed'(cfg.trim[ctrl.ch]);
   assign prod_in  = signed'({1'b0, amp_sel}) * sine_ff;

   assign centre_deg = 9'sd90 + 9'(trim_sel);
   assign centre     = {centre_deg[8], centre_deg, 8'd0};
   assign rnd        = (prod_ff + 24'sd64) >>> 7;
   assign sum        = 19'(centre) + 19'(rnd);

   always_comb begin
      priority if (sum < 19'sd0) begin
         ang_in = 16'd0;
      end else if (sum > signed'({3'd0, ANGLE_MAX_Q8})) begin
         ang_in = ANGLE_MAX_Q8;
      end else begin
         ang_in = sum[15:0];
      end
   end

   assign diff    = signed'({3'd0, ang_ff}) - 19'(centre);
   assign tol     = (ctrl.ch == 2'd0) ? 19'sd256 : 19'sd512;
   assign near    = (diff < tol) && (diff > -tol);
   assign elapsed = now_ff - last_ms_ff[ctrl.ch];
   assign due     = !parked_ff[ctrl.ch] && (elapsed >= 32'(UPDATE_INTERVAL_MS));

   always_comb begin
      priority if (centre_deg < 9'sd0) begin
         park_deg = 8'd0;
      end else if (centre_deg > 9'sd180) begin
         park_deg = 8'd180;
      end else begin
         park_deg = centre_deg[7:0];
      end
   end

   assign out_blocked = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (start) begin
         now_ff <= req_now_ms;
         run_ff <= req_run;
      end
      if (ctrl.fire) begin
         unique case (ctrl.op)
            OP_BASE: begin
               base_ff <= base_in;
            end
            OP_PHASE: begin
               idx_ff <= idx_in;
               neg_ff <= phase[31];
            end
            OP_SINE: begin
               sine_ff <= sine_in;
            end
            OP_PROD: begin
               prod_ff <= prod_in;
            end
            OP_ANGLE: begin
               ang_ff <= ang_in;
            end
            OP_COMMIT: begin
               wr_ff[ctrl.ch] <= due;
               if (!due) begin
                  deg_ff[ctrl.ch] <= 8'd0;
               end else if (!run_ff && near) begin
                  deg_ff[ctrl.ch] <= park_deg;
               end else begin
                  deg_ff[ctrl.ch] <= ang_ff[15:8];
               end
            end
            OP_DONE: begin
               rsp_wr_ff     <= wr_ff;
               rsp_deg_ff    <= deg_ff;
               rsp_parked_ff <= parked_ff;
            end
            default: begin
            end
         endcase
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         parked_ff    <= '0;
         for (int c = 0; c < NUM_CH; c++) begin
            last_ms_ff[c] <= 32'd0;
         end
      end else begin
         if (ctrl.fire && ctrl.op == OP_COMMIT && due) begin
            last_ms_ff[ctrl.ch] <= now_ff;
            if (!run_ff && near) begin
               parked_ff[ctrl.ch] <= 1'b1;
            end
         end
         if (ctrl.fire && ctrl.op == OP_DONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_base   = rsp_wr_ff[0];
   assign rsp_angle_base   = rsp_deg_ff[0];
   assign rsp_write_mid    = rsp_wr_ff[1];
   assign rsp_angle_mid    = rsp_deg_ff[1];
   assign rsp_write_tail   = rsp_wr_ff[2];
   assign rsp_angle_tail   = rsp_deg_ff[2];
   assign rsp_parked_flags = rsp_parked_ff;

endmodule

`default_nettype wire

// ===== rtl/core/three_servo_sine_wave_gait.sv =====
// Top level of the three-channel phase-offset sine-wave servo gait block.
//
//   channel   ports              direction   word
//   request   req_valid/stall    in          now_ms, run
//   response  rsp_valid/stall    out         write and angle per channel, parked flags
//   config    csr_write_en       in          register index and data
//
// An accepted word runs 17 sequencer steps (one phase setup, then phase, sine,
// multiply, angle and commit for each of three channels, then the result load),
// so the block takes no new word until the result load is done; the shared datapath sets that.
// A result waiting under rsp_stall holds the last step; the next word waits until it is taken.
// Synchronous reset clears channel timers, parked flags and loads register defaults.
`default_nettype none

module three_servo_sine_wave_gait
   import tssg_pkg::*;
#(
   parameter int UPDATE_INTERVAL_MS = 20
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [31:0]           req_now_ms,
   input  wire logic                  req_run,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_write_base,
   output logic [7:0]                 rsp_angle_base,
   output logic                       rsp_write_mid,
   output logic [7:0]                 rsp_angle_mid,
   output logic                       rsp_write_tail,
   output logic [7:0]                 rsp_angle_tail,
   output logic [2:0]                 rsp_parked_flags,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   ctrl_type ctrl;
   logic     busy;
   logic     start;
   logic     out_blocked;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FREQ_STEP:  cfg_in.freq_step  = csr_data;
            CSR_PHASE_STEP: cfg_in.phase_step = csr_data[15:0];
            CSR_AMP_BASE:   cfg_in.amp[0]     = csr_data[6:0];
            CSR_AMP_MID:    cfg_in.amp[1]     = csr_data[6:0];
            CSR_AMP_TAIL:   cfg_in.amp[2]     = csr_data[6:0];
            CSR_TRIM_BASE:  cfg_in.trim[0]    = csr_data[7:0];
            CSR_TRIM_MID:   cfg_in.trim[1]    = csr_data[7:0];
            CSR_TRIM_TAIL:  cfg_in.trim[2]    = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freq_step  <= 26'd2147484;
         cfg_ff.phase_step <= 16'd7301;
         cfg_ff.amp[0]     <= 7'd18;
         cfg_ff.amp[1]     <= 7'd28;
         cfg_ff.amp[2]     <= 7'd40;
         cfg_ff.trim[0]    <= 8'd6;
         cfg_ff.trim[1]    <= 8'd13;
         cfg_ff.trim[2]    <= 8'd17;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = busy || reset;
   assign start     = req_valid && !req_stall;

   tssg_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .out_blocked (out_blocked),
      .busy        (busy),
      .ctrl        (ctrl)
   );

   tssg_datapath #(
      .UPDATE_INTERVAL_MS (UPDATE_INTERVAL_MS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .ctrl             (ctrl),
      .start            (start),
      .req_now_ms       (req_now_ms),
      .req_run          (req_run),
      .rsp_stall        (rsp_stall),
      .out_blocked      (out_blocked),
      .rsp_valid        (rsp_valid),
      .rsp_write_base   (rsp_write_base),
      .rsp_angle_base   (rsp_angle_base),
      .rsp_write_mid    (rsp_write_mid),
      .rsp_angle_mid    (rsp_angle_mid),
      .rsp_write_tail   (rsp_write_tail),
      .rsp_angle_tail   (rsp_angle_tail),
      .rsp_parked_flags (rsp_parked_flags)
   );

endmodule

`default_nettype wire
